[src/modular_exponentiation_assert.svh]
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// condition holds at every edge
`define MEXP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, register map and modular add helper.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // payload field width
  localparam int FIELD_W = 63;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam logic REG_MODULUS = 1'b0;
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 63'd1000000007;

  // (x + y) mod m for x, y < m < 2^63
  function automatic logic [63:0] add_mod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [63:0] s;
    s = x + y;
    if (s >= m) begin
      s = s - m;
    end
    return s;
  endfunction

endpackage

[src/mexp_in_if.sv]
// ----------------------------------------------------------------------------
// mexp_in_if
// Operand channel: base and exponent with valid/ready.
// ----------------------------------------------------------------------------
interface mexp_in_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::FIELD_W-1:0] base;
  logic [mexp_pkg::FIELD_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

[src/mexp_out_if.sv]
// ----------------------------------------------------------------------------
// mexp_out_if
// Result channel: power_mod with valid/ready.
// ----------------------------------------------------------------------------
interface mexp_out_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::FIELD_W-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink (input valid, input power_mod, output ready);
endinterface

[src/modular_exponentiation.sv]
// Sequence: the base is reduced modulo m bit-serially, then one square-and-multiply
// step runs per exponent bit up to the highest set bit, then the output register
// is loaded; a zero modulus skips straight to the output with a result of 0.
// One item at a time: the next transfer is accepted only after the last result is
// loaded into the output register; the serial multipliers set the pace.
// Reset: synchronous active-low rst_n clears control and sets modulus to 1000000007.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply over the exponent, with a bit-serial base
// reduction and two bit-serial modular multipliers running side by side.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int OPERAND_BITS = 63
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mexp_in_if.sink                             in_ch,
  mexp_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mexp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mexp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mexp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import mexp_pkg::*;

  localparam int OPW   = OPERAND_BITS;
  localparam int CNT_W = $clog2(OPERAND_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_BITS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [FIELD_W-1:0] mod_r;
  logic [OPW-1:0]     mod_n;
  logic               cfg_wr;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [OPW-1:0]     b_r, b_nxt;
  logic [OPW-1:0]     e_r, e_nxt;
  logic [OPW-1:0]     rem_r, rem_nxt;
  logic [OPW-1:0]     sq_r, sq_nxt;
  logic [OPW-1:0]     acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_data_r, out_data_nxt;

  logic [OPW:0]       rem_sh;
  logic [OPW:0]       rem_sub;
  logic [OPW-1:0]     rem_red;
  logic               in_fire;
  logic               mul_start;
  logic               ac_done, sq_done;
  logic [OPW-1:0]     ac_prod, sq_prod;

  // configuration register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign mod_n  = mod_r[OPW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MODULUS_RESET;
    end else if (cfg_wr && (paddr[3] == REG_MODULUS)) begin
      mod_r <= pwdata[FIELD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3] == REG_MODULUS) begin
      prdata = CFG_DATA_W'(mod_r);
    end
  end

  // restoring reduction step of the base, one bit per cycle
  always_comb begin
    rem_sh  = {rem_r, b_r[OPW-1]};
    rem_sub = rem_sh - {1'b0, mod_n};
    rem_red = (rem_sh >= {1'b0, mod_n}) ? rem_sub[OPW-1:0] : rem_sh[OPW-1:0];
  end

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign mul_start = (state_r == S_STEP) && (e_r != '0);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    rem_nxt       = rem_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          b_nxt   = in_ch.base[OPW-1:0];
          e_nxt   = in_ch.exponent[OPW-1:0];
          cnt_nxt = '0;
          rem_nxt = '0;
          if (mod_n == '0) begin
            acc_nxt   = '0;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        rem_nxt = rem_red;
        b_nxt   = b_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          sq_nxt    = rem_red;
          acc_nxt   = (mod_n == OPW'(1)) ? '0 : OPW'(1);
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        // no set bits left: the result is final
        if (e_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sq_done) begin
          sq_nxt = sq_prod;
          if (e_r[0]) begin
            acc_nxt = ac_prod;
          end
          e_nxt     = e_r >> 1;
          state_nxt = S_STEP;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt  = FIELD_W'(acc_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    b_r        <= b_nxt;
    e_r        <= e_nxt;
    rem_r      <= rem_nxt;
    sq_r       <= sq_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // multiply and square units, started together
  mexp_mul #(.OPERAND_BITS(OPERAND_BITS)) u_mul_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (acc_r),
    .y     (sq_r),
    .m     (mod_n),
    .done  (ac_done),
    .prod  (ac_prod)
  );

  mexp_mul #(.OPERAND_BITS(OPERAND_BITS)) u_mul_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (sq_r),
    .y     (sq_r),
    .m     (mod_n),
    .done  (sq_done),
    .prod  (sq_prod)
  );

  // channel ports
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.power_mod = out_data_r;

  // checks
  `include "modular_exponentiation_assert.svh"

  `MEXP_ASSERT_ALWAYS(a_units_lockstep, ac_done == sq_done, "multiplier units out of step")
  `MEXP_ASSERT_ALWAYS(a_done_in_wait, !sq_done || (state_r == S_WAIT), "product outside wait")
  `MEXP_ASSERT_NEXT(a_zero_mod, in_fire && (mod_n == '0), (state_r == S_FINISH) && (acc_r == '0), "zero modulus path")
  `MEXP_ASSERT_NEXT(a_accept_next, in_fire, (state_r == S_REDUCE) || (state_r == S_FINISH), "bad state after transfer")

endmodule

[src/mexp_mul.sv]
// ----------------------------------------------------------------------------
// mexp_mul
// Bit-serial modular multiplier: one multiplier bit per cycle, shift-and-add
// with doubling, over all OPERAND_BITS bits of y. Operands must be below m.
// ----------------------------------------------------------------------------
module mexp_mul #(
  parameter int OPERAND_BITS = 63
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [OPERAND_BITS-1:0] x,
  input  logic [OPERAND_BITS-1:0] y,
  input  logic [OPERAND_BITS-1:0] m,
  output logic                    done,
  output logic [OPERAND_BITS-1:0] prod
);
  import mexp_pkg::*;

  localparam int CNT_W = $clog2(OPERAND_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_BITS - 1);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [OPERAND_BITS-1:0] x_r, x_nxt;
  logic [OPERAND_BITS-1:0] y_r, y_nxt;
  logic [OPERAND_BITS-1:0] acc_r, acc_nxt;
  logic [63:0]             acc_sum;
  logic [63:0]             x_dbl;

  // one step of the shift-and-add loop
  always_comb begin
    acc_sum  = add_mod(64'(acc_r), 64'(x_r), 64'(m));
    x_dbl    = add_mod(64'(x_r), 64'(x_r), 64'(m));
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = x;
      y_nxt    = y;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (y_r[0]) begin
        acc_nxt = acc_sum[OPERAND_BITS-1:0];
      end
      x_nxt   = x_dbl[OPERAND_BITS-1:0];
      y_nxt   = y_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
